[hw/rtl/assert_macros.svh]
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define PIDSA_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication violated");

// Next-cycle implication, off while reset is asserted.
`define PIDSA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication violated");

`endif

[hw/rtl/pidsa_pkg.sv]
package pidsa_pkg;

  localparam int unsigned PIX_W      = 14;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned DRV_W      = 16;
  localparam int unsigned ERR_W      = PIX_W + 1;
  localparam int unsigned PD_W       = 33;
  localparam int unsigned GIE_W      = 31;
  localparam int unsigned ACC_EXTRA  = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT    = 3'd0,
    CFG_SEP_THRESH  = 3'd1,
    CFG_GAIN_P      = 3'd2,
    CFG_GAIN_I      = 3'd3,
    CFG_GAIN_D      = 3'd4,
    CFG_DRIVE_UPPER = 3'd5,
    CFG_DRIVE_LOWER = 3'd6
  } cfg_idx_e;

  localparam logic [PIX_W-1:0]         SETPOINT_RST   = 14'd3520;
  localparam logic [PIX_W-1:0]         SEP_THRESH_RST = 14'd2400;
  localparam logic [GAIN_W-1:0]        GAIN_P_RST     = 16'd307;
  localparam logic [GAIN_W-1:0]        GAIN_I_RST     = 16'd26;
  localparam logic [GAIN_W-1:0]        GAIN_D_RST     = 16'd0;
  localparam logic signed [DRV_W-1:0]  UPPER_RST      = 16'sd6144;
  localparam logic signed [DRV_W-1:0]  LOWER_RST      = -16'sd6144;

  localparam logic signed [DRV_W-1:0]  DRIVE_MAX      = 16'sh7FFF;
  localparam logic signed [DRV_W-1:0]  DRIVE_MIN      = 16'sh8000;

  typedef struct packed {
    logic [PIX_W-1:0]        setpoint;
    logic [PIX_W-1:0]        sep_thresh;
    logic [GAIN_W-1:0]       gain_p;
    logic [GAIN_W-1:0]       gain_i;
    logic [GAIN_W-1:0]       gain_d;
    logic signed [DRV_W-1:0] drive_upper;
    logic signed [DRV_W-1:0] drive_lower;
  } cfg_t;

  // Word handed from the error stage to the integral stage.
  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic                    active;
    logic signed [PD_W-1:0]  pd;
    logic signed [GIE_W-1:0] gie;
  } front_t;

endpackage

[hw/rtl/pidsa_cfg.sv]
module pidsa_cfg import pidsa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SETPOINT:    cfg_d.setpoint    = cfg_wdata_i[PIX_W-1:0];
        CFG_SEP_THRESH:  cfg_d.sep_thresh  = cfg_wdata_i[PIX_W-1:0];
        CFG_GAIN_P:      cfg_d.gain_p      = cfg_wdata_i[GAIN_W-1:0];
        CFG_GAIN_I:      cfg_d.gain_i      = cfg_wdata_i[GAIN_W-1:0];
        CFG_GAIN_D:      cfg_d.gain_d      = cfg_wdata_i[GAIN_W-1:0];
        CFG_DRIVE_UPPER: cfg_d.drive_upper = $signed(cfg_wdata_i[DRV_W-1:0]);
        CFG_DRIVE_LOWER: cfg_d.drive_lower = $signed(cfg_wdata_i[DRV_W-1:0]);
        default: begin
          // drop writes to unmapped indexes
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{setpoint:    SETPOINT_RST,
                 sep_thresh:  SEP_THRESH_RST,
                 gain_p:      GAIN_P_RST,
                 gain_i:      GAIN_I_RST,
                 gain_d:      GAIN_D_RST,
                 drive_upper: UPPER_RST,
                 drive_lower: LOWER_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/pidsa_front.sv]
module pidsa_front import pidsa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [PIX_W-1:0] feedback_pixel_i,
  output logic             valid_o,
  input  logic             ready_i,
  output front_t           word_o
);

  logic                    a_valid_q, a_valid_d;
  logic [PIX_W-1:0]        fb_q;
  logic                    b_valid_q, b_valid_d;
  front_t                  b_q, b_d;
  logic signed [ERR_W-1:0] prev_err_q;

  logic a_ready, b_ready, a_load, b_load;

  logic signed [ERR_W-1:0] err;
  logic [ERR_W-1:0]        err_mag;
  logic signed [ERR_W:0]   err_diff;
  logic signed [PD_W-1:0]  gp_x, gd_x, err_x, diff_x, prod_p, prod_d;
  logic signed [GIE_W-1:0] gi_x, err_g;

  assign b_ready = !b_valid_q || ready_i;
  assign a_ready = !a_valid_q || b_ready;
  assign a_load  = valid_i && a_ready;
  assign b_load  = a_valid_q && b_ready;

  always_comb begin
    err      = $signed({1'b0, cfg_i.setpoint}) - $signed({1'b0, fb_q});
    err_mag  = err[ERR_W-1] ? $unsigned(-err) : $unsigned(err);
    err_diff = $signed({err[ERR_W-1], err}) - $signed({prev_err_q[ERR_W-1], prev_err_q});

    gp_x   = $signed(PD_W'(cfg_i.gain_p));
    gd_x   = $signed(PD_W'(cfg_i.gain_d));
    err_x  = PD_W'(err);
    diff_x = PD_W'(err_diff);
    prod_p = gp_x * err_x;
    prod_d = gd_x * diff_x;

    gi_x  = $signed(GIE_W'(cfg_i.gain_i));
    err_g = GIE_W'(err);

    b_d.err    = err;
    b_d.active = (err_mag <= {1'b0, cfg_i.sep_thresh});
    b_d.pd     = prod_p + prod_d;
    b_d.gie    = gi_x * err_g;

    a_valid_d = a_load ? 1'b1 : (b_load ? 1'b0 : a_valid_q);
    b_valid_d = b_load ? 1'b1 : (ready_i ? 1'b0 : b_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q  <= 1'b0;
      b_valid_q  <= 1'b0;
      prev_err_q <= '0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
      if (b_load) begin
        prev_err_q <= err;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      fb_q <= feedback_pixel_i;
    end
    if (b_load) begin
      b_q <= b_d;
    end
  end

  assign ready_o = a_ready;
  assign valid_o = b_valid_q;
  assign word_o  = b_q;

endmodule

[hw/rtl/pidsa_loop.sv]
module pidsa_loop import pidsa_pkg::*; #(
  parameter int unsigned SCALE_DIVISOR = 220,
  parameter int unsigned SUM_WIDTH     = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cfg_t                                cfg_i,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  front_t                              word_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic signed [SUM_WIDTH+ACC_EXTRA-1:0] acc_o,
  output logic                                active_o
);

  localparam int unsigned ACC_W = SUM_WIDTH + ACC_EXTRA;
  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
  localparam logic signed [ACC_W-1:0]     DIV     = ACC_W'(SCALE_DIVISOR);
  localparam logic signed [ACC_W-1:0]     ONE     = ACC_W'(1);

  logic                        c_valid_q, c_valid_d;
  logic signed [ACC_W-1:0]     acc_q;
  logic                        active_q;
  logic signed [SUM_WIDTH-1:0] sum_q, sum_d;
  logic signed [ACC_W-1:0]     iprod_q, iprod_d;
  logic signed [ACC_W-1:0]     prev_acc_q;
  logic signed [ACC_W-1:0]     mul_q, mul_d;
  logic                        busy_q;
  logic signed [ACC_W-1:0]     thr_hi_q, thr_hi_d, thr_lo_q, thr_lo_d;
  logic                        upper_top_q, upper_top_d, lower_bot_q, lower_bot_d;

  logic                        load;
  logic signed [ACC_W-1:0]     up_x, lo_x, up_scaled, lo_scaled;
  logic                        over, under, add, e_neg, e_pos;
  logic signed [SUM_WIDTH:0]   sum_try;
  logic                        ovf_pos, ovf_neg;
  logic signed [ACC_W-1:0]     gi_x, gi_top, gi_bot, gie_x, acc;

  assign ready_o = !c_valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // Drive limits mapped onto the unscaled sum, so the next word can test
  // the previous drive without waiting for the divide.
  always_comb begin
    up_x        = ACC_W'(cfg_i.drive_upper);
    lo_x        = ACC_W'(cfg_i.drive_lower);
    up_scaled   = up_x * DIV;
    lo_scaled   = lo_x * DIV;
    thr_hi_d    = cfg_i.drive_upper[DRV_W-1] ? up_scaled + ONE : up_scaled + DIV;
    thr_lo_d    = (cfg_i.drive_lower[DRV_W-1] || cfg_i.drive_lower == '0) ?
                  lo_scaled - DIV : lo_scaled - ONE;
    upper_top_d = (cfg_i.drive_upper == DRIVE_MAX);
    lower_bot_d = (cfg_i.drive_lower == DRIVE_MIN);
  end

  always_comb begin
    over  = !upper_top_q && (prev_acc_q >= thr_hi_q);
    under = !lower_bot_q && (prev_acc_q <= thr_lo_q);
    e_neg = word_i.err[ERR_W-1];
    e_pos = !e_neg && (word_i.err != '0);
    if (over) begin
      add = e_neg;
    end else if (under) begin
      add = e_pos;
    end else begin
      add = 1'b1;
    end

    sum_try = $signed({sum_q[SUM_WIDTH-1], sum_q}) + (SUM_WIDTH+1)'(word_i.err);
    ovf_pos = !sum_try[SUM_WIDTH] && sum_try[SUM_WIDTH-1];
    ovf_neg = sum_try[SUM_WIDTH] && !sum_try[SUM_WIDTH-1];

    gi_x   = $signed(ACC_W'(cfg_i.gain_i));
    gi_top = (gi_x <<< (SUM_WIDTH-1)) - gi_x;
    gi_bot = -(gi_x <<< (SUM_WIDTH-1));
    gie_x  = ACC_W'(word_i.gie);

    // Track gain_i * sum incrementally so no multiplier sits in the loop.
    sum_d   = sum_q;
    iprod_d = iprod_q;
    if (word_i.active && add) begin
      if (ovf_pos) begin
        sum_d   = SUM_MAX;
        iprod_d = gi_top;
      end else if (ovf_neg) begin
        sum_d   = SUM_MIN;
        iprod_d = gi_bot;
      end else begin
        sum_d   = $signed(sum_try[SUM_WIDTH-1:0]);
        iprod_d = iprod_q + gie_x;
      end
    end

    acc   = ACC_W'(word_i.pd) + (word_i.active ? iprod_d : '0);
    mul_d = gi_x * ACC_W'(sum_q);

    c_valid_d = load ? 1'b1 : (ready_i ? 1'b0 : c_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q   <= 1'b0;
      sum_q       <= '0;
      iprod_q     <= '0;
      prev_acc_q  <= '0;
      mul_q       <= '0;
      busy_q      <= 1'b0;
      thr_hi_q    <= '0;
      thr_lo_q    <= '0;
      upper_top_q <= 1'b0;
      lower_bot_q <= 1'b0;
    end else begin
      c_valid_q   <= c_valid_d;
      mul_q       <= mul_d;
      busy_q      <= load;
      thr_hi_q    <= thr_hi_d;
      thr_lo_q    <= thr_lo_d;
      upper_top_q <= upper_top_d;
      lower_bot_q <= lower_bot_d;
      if (load) begin
        sum_q      <= sum_d;
        iprod_q    <= iprod_d;
        prev_acc_q <= acc;
      end else if (!busy_q) begin
        // resync the product after a gain change once the loop is quiet
        iprod_q <= mul_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      acc_q    <= acc;
      active_q <= word_i.active;
    end
  end

  assign valid_o  = c_valid_q;
  assign acc_o    = acc_q;
  assign active_o = active_q;

endmodule

[hw/rtl/pidsa_scale.sv]
module pidsa_scale import pidsa_pkg::*; #(
  parameter int unsigned SCALE_DIVISOR = 220,
  parameter int unsigned SUM_WIDTH     = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic signed [SUM_WIDTH+ACC_EXTRA-1:0] acc_i,
  input  logic                                  active_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic signed [DRV_W-1:0]               drive_value_o,
  output logic                                  integral_active_o,
  output logic                                  drive_saturated_o
);

  localparam int unsigned ACC_W   = SUM_WIDTH + ACC_EXTRA;
  localparam int unsigned MAG_W   = $clog2(32769 * SCALE_DIVISOR);
  localparam int unsigned LOG_DIV = $clog2(SCALE_DIVISOR);
  localparam int unsigned SHIFT   = MAG_W + LOG_DIV;
  localparam int unsigned PROD_W  = 2 * MAG_W + 1;
  localparam logic [PROD_W-1:0] RECIP =
    PROD_W'(((64'd1 << SHIFT) + 64'(SCALE_DIVISOR) - 64'd1) / 64'(SCALE_DIVISOR));
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32768 * SCALE_DIVISOR);
  localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(32769 * SCALE_DIVISOR));

  logic                    d_valid_q, d_valid_d;
  logic                    d_sat_hi_q, d_sat_lo_q, d_neg_q, d_active_q;
  logic [MAG_W-1:0]        d_mag_q;
  logic                    e_valid_q, e_valid_d;
  logic signed [DRV_W-1:0] drive_q, drive_d;
  logic                    sat_q, active_q;

  logic                    d_ready, e_ready, d_load, e_load;
  logic signed [ACC_W-1:0] acc_abs;
  logic [PROD_W-1:0]       prod;
  logic [DRV_W-1:0]        q_mag;

  assign e_ready = !e_valid_q || ready_i;
  assign d_ready = !d_valid_q || e_ready;
  assign d_load  = valid_i && d_ready;
  assign e_load  = d_valid_q && e_ready;

  always_comb begin
    acc_abs = acc_i[ACC_W-1] ? -acc_i : acc_i;

    // exact truncating divide by reciprocal for magnitudes below 2^MAG_W
    prod  = PROD_W'(d_mag_q) * RECIP;
    q_mag = prod[SHIFT +: DRV_W];
    if (d_sat_hi_q) begin
      drive_d = DRIVE_MAX;
    end else if (d_sat_lo_q) begin
      drive_d = DRIVE_MIN;
    end else if (d_neg_q) begin
      drive_d = -$signed(q_mag);
    end else begin
      drive_d = $signed(q_mag);
    end

    d_valid_d = d_load ? 1'b1 : (e_load ? 1'b0 : d_valid_q);
    e_valid_d = e_load ? 1'b1 : (ready_i ? 1'b0 : e_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
    end else begin
      d_valid_q <= d_valid_d;
      e_valid_q <= e_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_load) begin
      d_sat_hi_q <= (acc_i >= SAT_HI);
      d_sat_lo_q <= (acc_i <= SAT_LO);
      d_neg_q    <= acc_i[ACC_W-1];
      d_mag_q    <= acc_abs[MAG_W-1:0];
      d_active_q <= active_i;
    end
    if (e_load) begin
      drive_q  <= drive_d;
      sat_q    <= d_sat_hi_q || d_sat_lo_q;
      active_q <= d_active_q;
    end
  end

  assign ready_o           = d_ready;
  assign valid_o           = e_valid_q;
  assign drive_value_o     = drive_q;
  assign integral_active_o = active_q;
  assign drive_saturated_o = sat_q;

endmodule

[hw/rtl/pid_integral_separation_antiwindup.sv]
// Positional PID controller with integral separation and anti-windup.
//
// Input word: feedback_pixel_i on in_valid_i / in_ready_o. Output word:
// drive_value_o, integral_active_o, drive_saturated_o on out_valid_o /
// out_ready_i. Gains, setpoint, separation threshold and drive limits are
// written through cfg_we_i / cfg_idx_i / cfg_wdata_i, one register per write,
// taking effect on the next cycle; write them only while no word is in flight.
//
// Pipeline: input register, error and products, integral update, clip and
// magnitude, reciprocal divide into the output register. One word is taken
// every cycle while the output is not stalled; the rate is set by the integral
// update stage, which carries the running sum, the gain-times-sum product and
// the previous unscaled drive for the anti-windup test in a loop that closes
// within that stage.
//
// Reset clears the integral, the previous error and the previous drive and
// loads the default register values. When out_ready_i is low the result is
// held in the output register and earlier stages keep filling until the
// pipeline is full; in_ready_o drops only then.
module pid_integral_separation_antiwindup import pidsa_pkg::*; #(
  parameter int unsigned SCALE_DIVISOR = 220,
  parameter int unsigned SUM_WIDTH     = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [PIX_W-1:0]        feedback_pixel_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DRV_W-1:0] drive_value_o,
  output logic                    integral_active_o,
  output logic                    drive_saturated_o
);

  localparam int unsigned ACC_W = SUM_WIDTH + ACC_EXTRA;

  cfg_t                    cfg;
  logic                    fe_valid, fe_ready;
  front_t                  fe_word;
  logic                    lp_valid, lp_ready;
  logic signed [ACC_W-1:0] lp_acc;
  logic                    lp_active;

  pidsa_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pidsa_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .valid_i          (in_valid_i),
    .ready_o          (in_ready_o),
    .feedback_pixel_i (feedback_pixel_i),
    .valid_o          (fe_valid),
    .ready_i          (fe_ready),
    .word_o           (fe_word)
  );

  pidsa_loop #(
    .SCALE_DIVISOR (SCALE_DIVISOR),
    .SUM_WIDTH     (SUM_WIDTH)
  ) u_loop (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (fe_valid),
    .ready_o  (fe_ready),
    .word_i   (fe_word),
    .valid_o  (lp_valid),
    .ready_i  (lp_ready),
    .acc_o    (lp_acc),
    .active_o (lp_active)
  );

  pidsa_scale #(
    .SCALE_DIVISOR (SCALE_DIVISOR),
    .SUM_WIDTH     (SUM_WIDTH)
  ) u_scale (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (lp_valid),
    .ready_o           (lp_ready),
    .acc_i             (lp_acc),
    .active_i          (lp_active),
    .valid_o           (out_valid_o),
    .ready_i           (out_ready_i),
    .drive_value_o     (drive_value_o),
    .integral_active_o (integral_active_o),
    .drive_saturated_o (drive_saturated_o)
  );

endmodule

[hw/rtl/pidsa_checker.sv]
`include "assert_macros.svh"

module pidsa_checker import pidsa_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic signed [DRV_W-1:0] drive_value_o,
  input logic                    integral_active_o,
  input logic                    drive_saturated_o
);

  // a clipped drive sits on one of the rails
  `PIDSA_ASSERT_IMPLY(a_sat_on_rail, clk_i, rst_ni, out_valid_o && drive_saturated_o, drive_value_o == DRIVE_MAX || drive_value_o == DRIVE_MIN)

  // a free output register frees the whole pipeline back to the input
  `PIDSA_ASSERT_IMPLY(a_ready_when_drained, clk_i, rst_ni, !out_valid_o || out_ready_i, in_ready_o)

  // hold the word while the receiver stalls
  `PIDSA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(drive_value_o) && $stable(integral_active_o) && $stable(drive_saturated_o))

endmodule

bind pid_integral_separation_antiwindup pidsa_checker u_pidsa_checker (.*);

[tb/pid_integral_separation_antiwindup_tb.sv]
module pid_integral_separation_antiwindup_tb;
  import pidsa_pkg::*;

  localparam int unsigned SCALE_DIVISOR = 220;
  localparam int unsigned SUM_WIDTH     = 32;
  localparam int          PIPE_DEPTH    = 4;
  localparam int          STALL_LIMIT   = 2000;
  localparam int          HOLD_CYCLES   = 80;
  localparam int          RANDOM_WORDS  = 108;
  localparam int          PIX_MAX       = (1 << PIX_W) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

  typedef struct packed {
    logic signed [DRV_W-1:0] drive;
    logic                    active;
    logic                    saturated;
  } drive_word_t;

  class drive_scoreboard;
    logic [PIX_W-1:0]        setpoint;
    logic [PIX_W-1:0]        sep_thresh;
    logic [GAIN_W-1:0]       gain_p;
    logic [GAIN_W-1:0]       gain_i;
    logic [GAIN_W-1:0]       gain_d;
    logic signed [DRV_W-1:0] drive_upper;
    logic signed [DRV_W-1:0] drive_lower;
    longint                  integral;
    int                      last_err;
    logic signed [DRV_W-1:0] last_drive;
    drive_word_t             expected_drives[$];
    int                      words_checked;
    int                      mismatches;

    function new();
      setpoint      = SETPOINT_RST;
      sep_thresh    = SEP_THRESH_RST;
      gain_p        = GAIN_P_RST;
      gain_i        = GAIN_I_RST;
      gain_d        = GAIN_D_RST;
      drive_upper   = UPPER_RST;
      drive_lower   = LOWER_RST;
      integral      = 0;
      last_err      = 0;
      last_drive    = '0;
      words_checked = 0;
      mismatches    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SETPOINT:    setpoint    = data[PIX_W-1:0];
        CFG_SEP_THRESH:  sep_thresh  = data[PIX_W-1:0];
        CFG_GAIN_P:      gain_p      = data;
        CFG_GAIN_I:      gain_i      = data;
        CFG_GAIN_D:      gain_d      = data;
        CFG_DRIVE_UPPER: drive_upper = data;
        CFG_DRIVE_LOWER: drive_lower = data;
        default: ;
      endcase
    endfunction

    // Advance the controller by one sample and queue the drive it produces.
    function void note_pixel(logic [PIX_W-1:0] px);
      int          err;
      int          mag;
      bit          accumulate;
      longint      acc;
      longint      quot;
      longint      sum_hi;
      drive_word_t w;
      err    = int'(setpoint) - int'(px);
      mag    = (err < 0) ? -err : err;
      sum_hi = (longint'(1) << (SUM_WIDTH - 1)) - 1;
      w.active = (mag <= int'(sep_thresh));
      // upper limit is tested first, so it wins when the limits cross
      if (last_drive > drive_upper)      accumulate = (err < 0);
      else if (last_drive < drive_lower) accumulate = (err > 0);
      else                               accumulate = 1'b1;
      if (w.active && accumulate) begin
        integral = integral + err;
        if (integral > sum_hi)          integral = sum_hi;
        else if (integral < -sum_hi - 1) integral = -sum_hi - 1;
      end
      acc = longint'(gain_p) * err + longint'(gain_d) * (err - last_err);
      if (w.active) acc += longint'(gain_i) * integral;
      quot = acc / longint'(SCALE_DIVISOR);
      w.saturated = 1'b1;
      if (quot > 32767)       w.drive = DRIVE_MAX;
      else if (quot < -32768) w.drive = DRIVE_MIN;
      else begin
        w.drive     = quot[DRV_W-1:0];
        w.saturated = 1'b0;
      end
      last_err   = err;
      last_drive = w.drive;
      expected_drives.push_back(w);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_word(logic signed [DRV_W-1:0] drive, logic active, logic saturated);
      drive_word_t want;
      words_checked++;
      if (expected_drives.size() == 0) begin
        report($sformatf("unexpected word drive=%0d", drive));
      end else begin
        want = expected_drives.pop_front();
        if (drive !== want.drive)
          report($sformatf("drive_value %0d, want %0d", drive, want.drive));
        if (active !== want.active)
          report($sformatf("integral_active %b, want %b", active, want.active));
        if (saturated !== want.saturated)
          report($sformatf("drive_saturated %b, want %b", saturated, want.saturated));
      end
    endtask
  endclass

  logic                    clk_i             = 1'b0;
  logic                    rst_ni            = 1'b0;
  logic                    cfg_we_i          = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i         = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i       = '0;
  logic                    in_valid_i        = 1'b0;
  logic                    in_ready_o;
  logic [PIX_W-1:0]        feedback_pixel_i  = '0;
  logic                    out_valid_o;
  logic                    out_ready_i       = 1'b0;
  logic signed [DRV_W-1:0] drive_value_o;
  logic                    integral_active_o;
  logic                    drive_saturated_o;

  drive_scoreboard  drive_check = new();
  logic [PIX_W-1:0] pixel_q[$];
  int               words_offered = 0;
  int               tx_idle_pct   = 6;
  int               rx_idle_pct   = 45;
  bit               hold_req      = 1'b0;
  int               quiet_cycles  = 0;

  pid_integral_separation_antiwindup #(
    .SCALE_DIVISOR(SCALE_DIVISOR),
    .SUM_WIDTH    (SUM_WIDTH)
  ) dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .feedback_pixel_i,
    .out_valid_o,
    .out_ready_i,
    .drive_value_o,
    .integral_active_o,
    .drive_saturated_o
  );

  always #10 clk_i = ~clk_i;

  // Sender: hold a word until taken, then pick up the next one or idle.
  initial begin : feeder
    logic busy;
    forever begin
      @(posedge clk_i);
      busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        drive_check.note_pixel(feedback_pixel_i);
        busy = 1'b0;
      end
      if (!busy) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid_i       <= 1'b1;
          feedback_pixel_i <= pixel_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  initial begin : sink
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      drive_check.check_word(drive_value_o, integral_active_o, drive_saturated_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic offer(input int px);
    pixel_q.push_back(px[PIX_W-1:0]);
    words_offered++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    drive_check.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (drive_check.words_checked < words_offered) @(posedge clk_i);
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_gain();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1023));
    endcase
  endfunction

  // Mostly land inside or on the edge of the separation band.
  function automatic int pick_pixel();
    int sp;
    int th;
    int v;
    sp = drive_check.setpoint;
    th = drive_check.sep_thresh;
    case ($urandom_range(9))
      0, 1:    v = $urandom_range(PIX_MAX);
      2:       v = $urandom_range(1) ? PIX_MAX : 0;
      3:       v = sp + ($urandom_range(1) ? th : -th) + int'($urandom_range(2)) - 1;
      default: v = sp + int'($urandom_range(2 * th)) - th;
    endcase
    if (v < 0)       v = 0;
    if (v > PIX_MAX) v = PIX_MAX;
    return v;
  endfunction

  task automatic random_setting();
    logic [CFG_DATA_W-1:0] thresh;
    logic [CFG_DATA_W-1:0] upper;
    logic [CFG_DATA_W-1:0] lower;
    case ($urandom_range(5))
      0:       thresh = '0;
      1:       thresh = 16'hFFFF;
      2:       thresh = 16'($urandom);
      default: thresh = 16'($urandom_range(3000));
    endcase
    case ($urandom_range(5))
      0:       upper = 16'h7FFF;
      1:       upper = 16'h8000;
      2:       upper = 16'($urandom);
      default: upper = 16'($urandom_range(12000));
    endcase
    case ($urandom_range(5))
      0:       lower = 16'h8000;
      1:       lower = 16'h7FFF;
      2:       lower = 16'($urandom);
      default: lower = 16'(-int'($urandom_range(12000)));
    endcase
    write_reg(CFG_SETPOINT, 16'($urandom));
    write_reg(CFG_SEP_THRESH, thresh);
    write_reg(CFG_GAIN_P, rand_gain());
    write_reg(CFG_GAIN_I, rand_gain());
    write_reg(CFG_GAIN_D, rand_gain());
    write_reg(CFG_DRIVE_UPPER, upper);
    write_reg(CFG_DRIVE_LOWER, lower);
  endtask

  initial begin : stimulus
    int reset_pixels[8];
    int extreme_pixels[4];
    int crossed_pixels[6];
    reset_pixels   = '{3520, 0, 16383, 1120, 1119, 5920, 5921, 3520};
    extreme_pixels = '{16383, 0, 16383, 1};
    crossed_pixels = '{8000, 8400, 8400, 0, 16383, 8192};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: on target, both edges of the separation band, full scale
    foreach (reset_pixels[k]) offer(reset_pixels[k]);
    wait_idle();

    write_reg(CFG_NO_REG, 16'h1234);          // no register there: drop
    write_reg(CFG_SETPOINT, 16'hFFFF);        // high bits fall away
    write_reg(CFG_SEP_THRESH, 16'hC000);      // leaves a zero threshold
    write_reg(CFG_GAIN_P, 16'hFFFF);
    write_reg(CFG_GAIN_I, 16'hFFFF);
    write_reg(CFG_GAIN_D, 16'hFFFF);
    write_reg(CFG_DRIVE_UPPER, 16'h7FFF);
    write_reg(CFG_DRIVE_LOWER, 16'h8000);
    // clip high, then clip low through the derivative step
    foreach (extreme_pixels[k]) offer(extreme_pixels[k]);
    wait_idle();

    // crossed limits: upper below lower
    write_reg(CFG_SETPOINT, 16'd8192);
    write_reg(CFG_SEP_THRESH, 16'd16383);
    write_reg(CFG_GAIN_P, 16'd256);
    write_reg(CFG_GAIN_I, 16'd256);
    write_reg(CFG_GAIN_D, 16'd0);
    write_reg(CFG_DRIVE_UPPER, 16'hFF9C);
    write_reg(CFG_DRIVE_LOWER, 16'd100);
    foreach (crossed_pixels[k]) offer(crossed_pixels[k]);
    wait_idle();

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 45 : 0;
      rx_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 6 : 0;
      for (int s = 0; s < 2; s++) begin
        random_setting();
        // stall the output long enough for the pipe to back up
        if (phase == 0 && s == 0) hold_req = 1'b1;
        repeat (RANDOM_WORDS) offer(pick_pixel());
        wait_idle();
      end
    end

    if (drive_check.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
